@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// shared assertion macros for the lcd sequencer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with asynchronous active-low reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication form
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/clcd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_pkg
// shared types, constants and init tables of the character lcd sequencer
// ----------------------------------------------------------------------------
package clcd_pkg;

	localparam int Rows       = 2;
	localparam int Columns    = 16;
	localparam int InitSteps  = 10;
	localparam int NibSteps   = 4;
	localparam int QueueDepth = 2;
	localparam int QueuePtrW  = $clog2(QueueDepth);
	localparam int QueueCntW  = $clog2(QueueDepth + 1);

	localparam logic [3:0] CountdownReset = 4'd15;

	// commands
	localparam logic [1:0] CmdTick   = 2'd0;
	localparam logic [1:0] CmdData   = 2'd1;
	localparam logic [1:0] CmdInstr  = 2'd2;
	localparam logic [1:0] CmdCursor = 2'd3;

	// status codes
	localparam logic [1:0] StatFrame    = 2'd0;
	localparam logic [1:0] StatRange    = 2'd1;
	localparam logic [1:0] StatNotReady = 2'd2;

	// job kinds between front and back
	localparam logic [1:0] KindSingle = 2'd0;
	localparam logic [1:0] KindNibble = 2'd1;
	localparam logic [1:0] KindByte   = 2'd2;

	localparam logic [2:0] PhaseLast = 3'd5;
	localparam logic [2:0] PhaseNibLast = 3'd2;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] value;
		logic [1:0] row;
		logic [5:0] column;
	} in_item_t;

	typedef struct packed {
		logic [7:0] link_byte;
		logic       last;
		logic [1:0] status;
		logic       ready_res;
	} out_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       rs;
		logic [1:0] status;
		logic       ready;
	} job_t;

	function automatic logic [7:0] seq_entry(input logic [3:0] step, input logic vis,
			input logic blink);
		logic [7:0] e;
		case (step) inside
			4'd0, 4'd1, 4'd2: e = 8'h30;
			4'd3: e = 8'h20;
			4'd4: e = 8'h28;
			4'd5: e = 8'h08;
			4'd6: e = 8'h01;
			4'd7: e = 8'h06;
			4'd8: e = {6'b000011, vis, blink};
			default: e = 8'h02;
		endcase
		return e;
	endfunction

	function automatic logic [3:0] seq_delay(input logic [3:0] step);
		logic [3:0] d;
		case (step) inside
			4'd0: d = 4'd5;
			4'd6, 4'd9: d = 4'd2;
			default: d = 4'd1;
		endcase
		return d;
	endfunction

endpackage

@@ rtl/clcd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_front
// accepts items, runs the power-on countdown and classifies requests into jobs
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clcd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  clcd_pkg::in_item_t  in_item,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic                cfg_data,
	output logic                push,
	output clcd_pkg::job_t      push_job
);

	logic [3:0] init_step_q;
	logic [3:0] countdown_q;
	logic       ready_flag_q;
	logic       cursor_visible_q;
	logic       cursor_blink_q;

	logic [3:0] init_step_d;
	logic [3:0] countdown_d;
	logic       ready_flag_d;
	logic       out_of_range;
	logic [6:0] cursor_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_visible_q <= 1'b0;
			cursor_blink_q   <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == 1'b0) begin
				cursor_visible_q <= cfg_data;
			end else begin
				cursor_blink_q <= cfg_data;
			end
		end
	end

	assign out_of_range = ({1'b0, in_item.row} >= 3'(clcd_pkg::Rows))
		|| (in_item.column >= 6'(clcd_pkg::Columns));
	assign cursor_addr = 7'({in_item.row, 6'b0}) + {1'b0, in_item.column};

	always_comb begin
		init_step_d     = init_step_q;
		countdown_d     = countdown_q;
		ready_flag_d    = ready_flag_q;
		push            = 1'b0;
		push_job.kind   = clcd_pkg::KindSingle;
		push_job.data   = 8'h00;
		push_job.rs     = 1'b0;
		push_job.status = clcd_pkg::StatFrame;
		push_job.ready  = ready_flag_q;
		if (accept) begin
			unique case (in_item.command) inside
				clcd_pkg::CmdTick: begin
					if (!ready_flag_q) begin
						if (countdown_q > 4'd1) begin
							countdown_d = countdown_q - 4'd1;
						end else if (init_step_q >= 4'(clcd_pkg::InitSteps)) begin
							ready_flag_d = 1'b1;
							countdown_d  = 4'd0;
						end else begin
							push          = 1'b1;
							push_job.data = clcd_pkg::seq_entry(init_step_q,
								cursor_visible_q, cursor_blink_q);
							push_job.kind = (init_step_q < 4'(clcd_pkg::NibSteps))
								? clcd_pkg::KindNibble : clcd_pkg::KindByte;
							countdown_d   = clcd_pkg::seq_delay(init_step_q);
							init_step_d   = init_step_q + 4'd1;
						end
					end
				end
				clcd_pkg::CmdData, clcd_pkg::CmdInstr: begin
					push = 1'b1;
					if (!ready_flag_q) begin
						push_job.status = clcd_pkg::StatNotReady;
					end else begin
						push_job.kind = clcd_pkg::KindByte;
						push_job.data = in_item.value;
						push_job.rs   = (in_item.command == clcd_pkg::CmdData);
					end
				end
				clcd_pkg::CmdCursor: begin
					push = 1'b1;
					if (!ready_flag_q) begin
						push_job.status = clcd_pkg::StatNotReady;
					end else if (out_of_range) begin
						push_job.status = clcd_pkg::StatRange;
					end else begin
						push_job.kind = clcd_pkg::KindByte;
						push_job.data = {1'b1, cursor_addr};
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_step_q  <= 4'd0;
			countdown_q  <= clcd_pkg::CountdownReset;
			ready_flag_q <= 1'b0;
		end else begin
			init_step_q  <= init_step_d;
			countdown_q  <= countdown_d;
			ready_flag_q <= ready_flag_d;
		end
	end

	`ASSERT_IMPL(a_ready_after_seq, clk, arst_n, ready_flag_q,
		init_step_q == 4'(clcd_pkg::InitSteps), "ready before init sequence finished")
	`ASSERT_IMPL(a_step_bound, clk, arst_n, 1'b1,
		init_step_q <= 4'(clcd_pkg::InitSteps), "init step past end of sequence")

endmodule

@@ rtl/clcd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clcd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  clcd_pkg::job_t push_job,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output clcd_pkg::job_t head
);

	clcd_pkg::job_t                   mem_q [clcd_pkg::QueueDepth];
	logic [clcd_pkg::QueuePtrW-1:0]   wr_ptr_q;
	logic [clcd_pkg::QueuePtrW-1:0]   rd_ptr_q;
	logic [clcd_pkg::QueueCntW-1:0]   count_q;
	logic                             do_push;
	logic                             do_pop;

	assign full      = (count_q == clcd_pkg::QueueCntW'(clcd_pkg::QueueDepth));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == clcd_pkg::QueuePtrW'(clcd_pkg::QueueDepth - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == clcd_pkg::QueuePtrW'(clcd_pkg::QueueDepth - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_CLK(a_count_bound, clk, arst_n,
		count_q <= clcd_pkg::QueueCntW'(clcd_pkg::QueueDepth), "queue count overflow")

endmodule

@@ rtl/clcd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_back
// expands one job into link bytes, one per cycle, held until taken
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clcd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_avail,
	input  clcd_pkg::job_t      head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output clcd_pkg::out_item_t out_item
);

	clcd_pkg::job_t job_q;
	logic           job_valid_q;
	logic [2:0]     phase_q;
	logic           is_last;
	logic           advance;
	logic [3:0]     nibble;
	logic           enable;

	assign is_last = (job_q.kind == clcd_pkg::KindSingle)
		|| (job_q.kind == clcd_pkg::KindNibble && phase_q == clcd_pkg::PhaseNibLast)
		|| (phase_q == clcd_pkg::PhaseLast);
	assign advance = job_valid_q && out_ready;
	assign pop     = !job_valid_q || (advance && is_last);

	assign nibble = (phase_q < 3'd3) ? job_q.data[7:4] : job_q.data[3:0];
	assign enable = (phase_q == 3'd1) || (phase_q == 3'd4);

	always_comb begin
		out_item.last      = is_last;
		out_item.status    = job_q.status;
		out_item.ready_res = job_q.ready;
		if (job_q.kind == clcd_pkg::KindSingle) begin
			out_item.link_byte = 8'h00;
		end else begin
			out_item.link_byte = {nibble, 2'b00, enable, job_q.rs};
		end
	end

	assign out_valid = job_valid_q;

	always_ff @(posedge clk) begin
		if (pop && job_avail) begin
			job_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			phase_q     <= 3'd0;
		end else if (pop) begin
			job_valid_q <= job_avail;
			phase_q     <= 3'd0;
		end else if (advance) begin
			phase_q <= phase_q + 3'd1;
		end
	end

	`ASSERT_IMPL(a_idle_phase, clk, arst_n, !job_valid_q, phase_q == 3'd0,
		"phase moved without a job")
	`ASSERT_IMPL(a_phase_kind, clk, arst_n, job_valid_q && phase_q > clcd_pkg::PhaseNibLast,
		job_q.kind == clcd_pkg::KindByte, "full-byte phase on a short job")

endmodule

@@ rtl/char_lcd_nibble_frame_init_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_frame_init_sequencer
// 4-bit character lcd sequencer producing a shift-register byte stream
// ----------------------------------------------------------------------------
// Every lcd byte leaves as six link bytes (high nibble with E low, high, low,
// then the low nibble), one per cycle from the back end while out_ready is
// high, so a data, instruction or cursor item gives six link bytes, an early
// power-on entry three and a status result one. The front end takes one item
// per cycle while the queue is not full and handles ticks that produce nothing
// on its own; a two-entry job queue lets it run ahead of the output while a
// link byte waits to be taken. After reset, ticks drive the ten-entry
// power-on sequence; requests before it completes return status 2.

module char_lcd_nibble_frame_init_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  clcd_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output clcd_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic                cfg_data
);

	logic           full;
	logic           not_empty;
	logic           push;
	logic           pop;
	clcd_pkg::job_t push_job;
	clcd_pkg::job_t head;

	assign in_ready = !full;

	clcd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_valid && in_ready),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.push_job  (push_job)
	);

	clcd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	clcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_avail (not_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

@@ tb/sv/char_lcd_nibble_frame_init_sequencer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_frame_init_sequencer_tb
// checks the lcd link-byte stream of the power-on sequence and of requests
// ----------------------------------------------------------------------------
// A directed table covers requests before the display is ready, then ticks
// walk the whole power-on sequence with the cursor bits changed part way.
// After that, directed and random requests follow. Every accepted item is
// expanded into its link bytes by a local model of the sequencer, and each
// link byte that leaves the block is compared field by field, in order. Both
// sides idle at random, with one stretch that runs without gaps.
module char_lcd_nibble_frame_init_sequencer_tb;

	localparam int SETTLE_CYCLES = 20;
	localparam int QUIET_LIMIT   = 1000;
	localparam int RANDOM_ITEMS  = 50;
	localparam int PRE_ROWS      = 4;
	localparam int ROW_COUNT     = 18;

	localparam logic REG_CURSOR_VISIBLE = 1'b0;
	localparam logic REG_CURSOR_BLINK   = 1'b1;

	localparam logic [7:0] BOOT_CODES [10] = '{8'h30, 8'h30, 8'h30, 8'h20, 8'h28,
		8'h08, 8'h01, 8'h06, 8'h0C, 8'h02};
	localparam logic [3:0] BOOT_WAITS [10] = '{4'd5, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd1, 4'd2, 4'd1, 4'd1, 4'd2};

	typedef struct packed {
		clcd_pkg::in_item_t  item;
		logic                typed;
		clcd_pkg::out_item_t want;
	} stim_row_t;

	localparam clcd_pkg::out_item_t NO_RESULT  = '0;
	localparam clcd_pkg::out_item_t EARLY_REQ  =
		'{8'h00, 1'b1, clcd_pkg::StatNotReady, 1'b0};
	localparam clcd_pkg::out_item_t BAD_CURSOR =
		'{8'h00, 1'b1, clcd_pkg::StatRange, 1'b1};

	localparam stim_row_t DIRECTED [ROW_COUNT] = '{
		// before the power-on sequence is done
		'{'{clcd_pkg::CmdData,   8'hFF, 2'd0, 6'd0},  1'b1, EARLY_REQ},
		'{'{clcd_pkg::CmdInstr,  8'h00, 2'd3, 6'd63}, 1'b1, EARLY_REQ},
		'{'{clcd_pkg::CmdCursor, 8'h00, 2'd0, 6'd0},  1'b1, EARLY_REQ},
		'{'{clcd_pkg::CmdCursor, 8'hFF, 2'd3, 6'd63}, 1'b1, EARLY_REQ},
		// ready
		'{'{clcd_pkg::CmdTick,   8'hFF, 2'd3, 6'd63}, 1'b0, NO_RESULT},
		'{'{clcd_pkg::CmdData,   8'h00, 2'd0, 6'd0},  1'b0, NO_RESULT},
		'{'{clcd_pkg::CmdData,   8'hFF, 2'd3, 6'd63}, 1'b0, NO_RESULT},
		'{'{clcd_pkg::CmdInstr,  8'h00, 2'd0, 6'd0},  1'b0, NO_RESULT},
		'{'{clcd_pkg::CmdInstr,  8'hFF, 2'd3, 6'd63}, 1'b0, NO_RESULT},
		'{'{clcd_pkg::CmdData,   8'h5A, 2'd1, 6'd21}, 1'b0, NO_RESULT},
		'{'{clcd_pkg::CmdCursor, 8'hFF, 2'd0, 6'd0},  1'b0, NO_RESULT},
		'{'{clcd_pkg::CmdCursor, 8'h00, 2'd1, 6'd15}, 1'b0, NO_RESULT},
		'{'{clcd_pkg::CmdCursor, 8'h00, 2'd0, 6'd15}, 1'b0, NO_RESULT},
		'{'{clcd_pkg::CmdCursor, 8'h00, 2'd1, 6'd0},  1'b0, NO_RESULT},
		// cursor out of range
		'{'{clcd_pkg::CmdCursor, 8'h00, 2'd0, 6'd16}, 1'b1, BAD_CURSOR},
		'{'{clcd_pkg::CmdCursor, 8'h00, 2'd2, 6'd0},  1'b1, BAD_CURSOR},
		'{'{clcd_pkg::CmdCursor, 8'hFF, 2'd3, 6'd63}, 1'b1, BAD_CURSOR},
		'{'{clcd_pkg::CmdCursor, 8'h00, 2'd1, 6'd63}, 1'b1, BAD_CURSOR}
	};

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	clcd_pkg::in_item_t  in_item;
	logic                out_valid;
	logic                out_ready = 1'b0;
	clcd_pkg::out_item_t out_item;
	logic                cfg_we;
	logic                cfg_index;
	logic                cfg_data;

	clcd_pkg::out_item_t expected_links [$];
	logic [3:0] boot_step;
	logic [3:0] boot_wait;
	logic       lcd_ready;
	logic       cur_vis;
	logic       cur_blink;
	int         mismatches = 0;
	int         quiet_cycles = 0;
	bit         steady;

	char_lcd_nibble_frame_init_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic push_link(input logic [7:0] b, input logic [1:0] st, input logic fin);
		clcd_pkg::out_item_t o;
		o.link_byte = b;
		o.last      = fin;
		o.status    = st;
		o.ready_res = lcd_ready;
		expected_links.push_back(o);
	endtask

	task automatic push_nibble(input logic [3:0] nib, input logic rs, input logic fin);
		logic [7:0] base;
		base = {nib, 3'b000, rs};
		push_link(base, clcd_pkg::StatFrame, 1'b0);
		push_link(base | 8'h02, clcd_pkg::StatFrame, 1'b0);
		push_link(base, clcd_pkg::StatFrame, fin);
	endtask

	task automatic push_lcd_byte(input logic [7:0] b, input logic rs);
		push_nibble(b[7:4], rs, 1'b0);
		push_nibble(b[3:0], rs, 1'b1);
	endtask

	// link bytes that one accepted item gives
	task automatic expand_request(input clcd_pkg::in_item_t it);
		logic [7:0] code;
		logic [6:0] addr;
		if (it.command == clcd_pkg::CmdTick) begin
			if (!lcd_ready) begin
				if (boot_wait > 4'd1) begin
					boot_wait = boot_wait - 4'd1;
				end else if (boot_step >= clcd_pkg::InitSteps) begin
					lcd_ready = 1'b1;
					boot_wait = 4'd0;
				end else begin
					code = BOOT_CODES[boot_step];
					if (boot_step == 4'd8)
						code = {6'b000011, cur_vis, cur_blink};
					boot_wait = BOOT_WAITS[boot_step];
					if (boot_step < clcd_pkg::NibSteps)
						push_nibble(code[7:4], 1'b0, 1'b1);
					else
						push_lcd_byte(code, 1'b0);
					boot_step = boot_step + 4'd1;
				end
			end
		end else if (!lcd_ready) begin
			push_link(8'h00, clcd_pkg::StatNotReady, 1'b1);
		end else if (it.command == clcd_pkg::CmdData) begin
			push_lcd_byte(it.value, 1'b1);
		end else if (it.command == clcd_pkg::CmdInstr) begin
			push_lcd_byte(it.value, 1'b0);
		end else if (it.row >= clcd_pkg::Rows || it.column >= clcd_pkg::Columns) begin
			push_link(8'h00, clcd_pkg::StatRange, 1'b1);
		end else begin
			addr = 7'(it.column + it.row * 8'h40);
			push_lcd_byte({1'b1, addr}, 1'b0);
		end
	endtask

	task automatic park();
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	// starts and ends at a falling edge
	task automatic send_item(input clcd_pkg::in_item_t it, input logic typed,
			input clcd_pkg::out_item_t want);
		while (!steady && $urandom_range(99) < 8)
			park();
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
		if (typed)
			expected_links.push_back(want);
		else
			expand_request(it);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		while (expected_links.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic val);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_CURSOR_VISIBLE)
			cur_vis = val;
		else
			cur_blink = val;
	endtask

	always @(negedge clk) begin
		out_ready <= steady || $urandom_range(99) >= 8;
	end

	always @(posedge clk) begin
		clcd_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_links.size() == 0) begin
				$error("unexpected link byte %02h", out_item.link_byte);
				mismatches++;
			end else begin
				want = expected_links.pop_front();
				if (out_item.link_byte !== want.link_byte) begin
					$error("link_byte: expected %02h, got %02h", want.link_byte,
						out_item.link_byte);
					mismatches++;
				end
				if (out_item.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, out_item.last);
					mismatches++;
				end
				if (out_item.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, out_item.status);
					mismatches++;
				end
				if (out_item.ready_res !== want.ready_res) begin
					$error("ready_res: expected %0d, got %0d", want.ready_res,
						out_item.ready_res);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		clcd_pkg::in_item_t req;
		int pick;
		bit reconfigured;
		in_valid     = 1'b0;
		in_item      = '0;
		cfg_we       = 1'b0;
		cfg_index    = 1'b0;
		cfg_data     = 1'b0;
		boot_step    = 4'd0;
		boot_wait    = clcd_pkg::CountdownReset;
		lcd_ready    = 1'b0;
		cur_vis      = 1'b0;
		cur_blink    = 1'b0;
		steady       = 1'b0;
		reconfigured = 1'b0;
		arst_n       = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_reg(REG_CURSOR_VISIBLE, 1'b1);
		write_reg(REG_CURSOR_BLINK, 1'b1);
		for (int i = 0; i < PRE_ROWS; i++)
			send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);

		// power-on sequence, cursor bits changed before the display-on entry
		while (!lcd_ready) begin
			if (boot_step == 4'd5 && !reconfigured) begin
				park();
				write_reg(REG_CURSOR_VISIBLE, 1'($urandom_range(1)));
				write_reg(REG_CURSOR_BLINK, 1'($urandom_range(1)));
				reconfigured = 1'b1;
			end
			req.command = clcd_pkg::CmdTick;
			req.value   = 8'($urandom_range(255));
			req.row     = 2'($urandom_range(3));
			req.column  = 6'($urandom_range(63));
			send_item(req, 1'b0, NO_RESULT);
		end

		park();
		write_reg(REG_CURSOR_VISIBLE, 1'b0);
		write_reg(REG_CURSOR_BLINK, 1'b0);
		for (int i = PRE_ROWS; i < ROW_COUNT; i++)
			send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= 10 && n < 30);
			if (n == 35) begin
				park();
				while (expected_links.size() != 0)
					@(negedge clk);
				write_reg(REG_CURSOR_VISIBLE, 1'b1);
			end
			pick        = $urandom_range(99);
			req.value   = 8'($urandom_range(255));
			req.row     = 2'($urandom_range(3));
			req.column  = 6'($urandom_range(63));
			if (pick < 10) begin
				req.command = clcd_pkg::CmdTick;
			end else if (pick < 40) begin
				req.command = clcd_pkg::CmdData;
			end else if (pick < 65) begin
				req.command = clcd_pkg::CmdInstr;
			end else begin
				req.command = clcd_pkg::CmdCursor;
				if ($urandom_range(3) != 0) begin
					req.row    = 2'($urandom_range(clcd_pkg::Rows - 1));
					req.column = 6'($urandom_range(clcd_pkg::Columns - 1));
				end
			end
			send_item(req, 1'b0, NO_RESULT);
		end
		steady = 1'b0;

		park();
		wait_idle();
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
